[design/skc_pkg.sv]
package skc_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int TOP_SLOTS       = 3;

   localparam int CMD_W   = 2;
   localparam int KEY_W   = 64;
   localparam int RANK_W  = 2;
   localparam int CNT_W   = 32;
   localparam int HIT_W   = 33;
   localparam int TOTAL_W = 11;

   localparam logic signed [HIT_W-1:0] HIT_ABSENT = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_HIT   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_RANK  = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEARCH_START,
      ST_SEARCH,
      ST_BUMP,
      ST_SORT_A,
      ST_SORT_B,
      ST_SORT_C,
      ST_INSERT,
      ST_RANK_READ,
      ST_RANK_DATA,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      RK_NONE,
      RK_LOAD,
      RK_BUMP,
      RK_SORT01,
      RK_SORT02,
      RK_SORT12,
      RK_INSERT
   } rank_op_type;

   typedef struct packed {
      rank_op_type             op;
      logic [CNT_W-1:0]        count;
   } rank_cmd_type;

endpackage

[design/skc_ifs.sv]
interface skc_req_if;
   logic                          valid;
   logic                          ready;
   logic [skc_pkg::CMD_W-1:0]     command;
   logic [skc_pkg::KEY_W-1:0]     key;
   logic [skc_pkg::RANK_W-1:0]    rank;

   modport source (output valid, output command, output key, output rank, input ready);
   modport sink   (input valid, input command, input key, input rank, output ready);
endinterface

interface skc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                found;
   logic signed [skc_pkg::HIT_W-1:0]    hit_count;
   logic [skc_pkg::KEY_W-1:0]           ranked_key;
   logic [skc_pkg::TOTAL_W-1:0]         entry_total;
   logic                                table_full;

   modport source (output valid, output found, output hit_count, output ranked_key,
                   output entry_total, output table_full, input ready);
   modport sink   (input valid, input found, input hit_count, input ranked_key,
                   input entry_total, input table_full, output ready);
endinterface

[design/skc_ram.sv]
module skc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[design/skc_rank.sv]
module skc_rank #(
   parameter int TABLE_DEPTH = skc_pkg::TABLE_DEPTH_DEF,
   localparam int IdxW = $clog2(TABLE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  skc_pkg::rank_cmd_type         cmd,
   input  logic [IdxW-1:0]               cmd_idx,
   input  logic [skc_pkg::RANK_W-1:0]    sel_rank,
   output logic                          sel_valid,
   output logic [IdxW-1:0]               sel_idx
);

   localparam int SlotN = skc_pkg::TOP_SLOTS;
   localparam int SlotW = $clog2(SlotN);

   logic [IdxW-1:0]           slot_idx_ff [SlotN];
   logic [IdxW-1:0]           slot_idx_in [SlotN];
   logic [SlotN-1:0]          slot_vld_ff;
   logic [SlotN-1:0]          slot_vld_in;
   logic [skc_pkg::CNT_W-1:0] slot_cnt_ff [SlotN];
   logic [skc_pkg::CNT_W-1:0] slot_cnt_in [SlotN];

   logic [SlotW-1:0] cmp_a;
   logic [SlotW-1:0] cmp_b;
   logic             swap_less;
   logic [SlotN-1:0] met;
   logic [SlotN-1:0] beat;
   logic             ins_do;
   logic             ins_done;
   logic [SlotW-1:0] ins_pos;
   logic [SlotW-1:0] load_pos;

   // shared compare: empty slot ranks below every entry
   always_comb begin
      case (cmd.op)
         skc_pkg::RK_SORT02: begin
            cmp_a = SlotW'(0);
            cmp_b = SlotW'(2);
         end
         skc_pkg::RK_SORT12: begin
            cmp_a = SlotW'(1);
            cmp_b = SlotW'(2);
         end
         default: begin
            cmp_a = SlotW'(0);
            cmp_b = SlotW'(1);
         end
      endcase
      swap_less = slot_vld_ff[cmp_b] &&
                  (!slot_vld_ff[cmp_a] || (slot_cnt_ff[cmp_a] < slot_cnt_ff[cmp_b]));
   end

   always_comb begin
      ins_done = 1'b0;
      ins_do   = 1'b0;
      ins_pos  = '0;
      for (int i = 0; i < SlotN; i++) begin
         met[i]  = slot_vld_ff[i] && (slot_idx_ff[i] == cmd_idx);
         beat[i] = !slot_vld_ff[i] || (cmd.count > slot_cnt_ff[i]);
         if (!ins_done) begin
            if (met[i]) begin
               ins_done = 1'b1;
            end else if (beat[i]) begin
               ins_done = 1'b1;
               ins_do   = 1'b1;
               ins_pos  = SlotW'(i);
            end
         end
      end
   end

   always_comb begin
      slot_idx_in = slot_idx_ff;
      slot_vld_in = slot_vld_ff;
      slot_cnt_in = slot_cnt_ff;
      load_pos    = cmd_idx[SlotW-1:0];
      case (cmd.op)
         skc_pkg::RK_LOAD: begin
            slot_idx_in[load_pos] = cmd_idx;
            slot_vld_in[load_pos] = 1'b1;
            slot_cnt_in[load_pos] = '0;
         end
         skc_pkg::RK_BUMP: begin
            for (int i = 0; i < SlotN; i++) begin
               if (met[i]) begin
                  slot_cnt_in[i] = cmd.count;
               end
            end
         end
         skc_pkg::RK_SORT01, skc_pkg::RK_SORT02, skc_pkg::RK_SORT12: begin
            if (swap_less) begin
               slot_idx_in[cmp_a] = slot_idx_ff[cmp_b];
               slot_vld_in[cmp_a] = slot_vld_ff[cmp_b];
               slot_cnt_in[cmp_a] = slot_cnt_ff[cmp_b];
               slot_idx_in[cmp_b] = slot_idx_ff[cmp_a];
               slot_vld_in[cmp_b] = slot_vld_ff[cmp_a];
               slot_cnt_in[cmp_b] = slot_cnt_ff[cmp_a];
            end
         end
         skc_pkg::RK_INSERT: begin
            if (ins_do) begin
               case (ins_pos)
                  SlotW'(0): begin
                     slot_idx_in[2] = slot_idx_ff[1];
                     slot_vld_in[2] = slot_vld_ff[1];
                     slot_cnt_in[2] = slot_cnt_ff[1];
                     slot_idx_in[1] = slot_idx_ff[0];
                     slot_vld_in[1] = slot_vld_ff[0];
                     slot_cnt_in[1] = slot_cnt_ff[0];
                     slot_idx_in[0] = cmd_idx;
                     slot_vld_in[0] = 1'b1;
                     slot_cnt_in[0] = cmd.count;
                  end
                  SlotW'(1): begin
                     slot_idx_in[2] = slot_idx_ff[1];
                     slot_vld_in[2] = slot_vld_ff[1];
                     slot_cnt_in[2] = slot_cnt_ff[1];
                     slot_idx_in[1] = cmd_idx;
                     slot_vld_in[1] = 1'b1;
                     slot_cnt_in[1] = cmd.count;
                  end
                  SlotW'(2): begin
                     slot_idx_in[2] = cmd_idx;
                     slot_vld_in[2] = 1'b1;
                     slot_cnt_in[2] = cmd.count;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (sel_rank)
         2'd0: begin
            sel_valid = slot_vld_ff[0];
            sel_idx   = slot_idx_ff[0];
         end
         2'd1: begin
            sel_valid = slot_vld_ff[1];
            sel_idx   = slot_idx_ff[1];
         end
         2'd2: begin
            sel_valid = slot_vld_ff[2];
            sel_idx   = slot_idx_ff[2];
         end
         default: begin
            sel_valid = 1'b0;
            sel_idx   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
      end else begin
         slot_vld_ff <= slot_vld_in;
      end
      slot_idx_ff <= slot_idx_in;
      slot_cnt_ff <= slot_cnt_in;
   end

   a_vld_prefix_lo: assert property (@(posedge clock) disable iff (reset)
      slot_vld_ff[1] |-> slot_vld_ff[0])
      else $error("ranked slot 1 filled above an empty slot 0");

   a_vld_prefix_hi: assert property (@(posedge clock) disable iff (reset)
      slot_vld_ff[2] |-> slot_vld_ff[1])
      else $error("ranked slot 2 filled above an empty slot 1");

   a_slot_distinct: assert property (@(posedge clock) disable iff (reset)
      !(slot_vld_ff[0] && slot_vld_ff[1] && (slot_idx_ff[0] == slot_idx_ff[1])) &&
      !(slot_vld_ff[0] && slot_vld_ff[2] && (slot_idx_ff[0] == slot_idx_ff[2])) &&
      !(slot_vld_ff[1] && slot_vld_ff[2] && (slot_idx_ff[1] == slot_idx_ff[2])))
      else $error("same entry held in two ranked slots");

endmodule

[design/sorted_key_counter_top_three_unit.sv]
// Key table with hit counters and a ranked top-three list. Load keys in ascending
// unsigned order with command 0, then record hits (1), query counts (2) or read the
// key at a rank (3); every item returns exactly one result, held in an output
// register so the next item can be taken while it waits. Key and count tables are
// single-port-read memories; lookups run a binary search that probes one midpoint a
// cycle through their read port. A search makes at most floor(log2(entries)) + 1 probes,
// i.e. 11 at 1024 entries. A hit on a present key then writes its count back and runs
// the sort and insert steps on the ranked list; a rank read fetches key and count only
// when the rank holds an entry. An item also holds in its finish state for as long as
// the previous result still waits in the output register. The request side is not
// ready while an item is at work.
module sorted_key_counter_top_three_unit #(
   parameter int TABLE_DEPTH = skc_pkg::TABLE_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   skc_req_if.sink    req_if,
   skc_rsp_if.source  rsp_if
);

   localparam int IdxW = $clog2(TABLE_DEPTH);
   localparam int TotW = $clog2(TABLE_DEPTH + 1);

   skc_pkg::state_type   state_ff;
   skc_pkg::state_type   state_in;
   skc_pkg::command_type cmd_ff;
   skc_pkg::command_type cmd_in;

   logic [skc_pkg::KEY_W-1:0]  key_ff;
   logic [skc_pkg::KEY_W-1:0]  key_in;
   logic [skc_pkg::RANK_W-1:0] rank_ff;
   logic [skc_pkg::RANK_W-1:0] rank_in;
   logic [TotW-1:0]            total_ff;
   logic [TotW-1:0]            total_in;
   logic [TotW-1:0]            lo_ff;
   logic [TotW-1:0]            lo_in;
   logic [TotW-1:0]            hi1_ff;
   logic [TotW-1:0]            hi1_in;
   logic [IdxW-1:0]            mid_ff;
   logic [IdxW-1:0]            mid_in;
   logic [skc_pkg::CNT_W-1:0]  new_cnt_ff;
   logic [skc_pkg::CNT_W-1:0]  new_cnt_in;

   logic                              res_found_ff;
   logic                              res_found_in;
   logic signed [skc_pkg::HIT_W-1:0]  res_count_ff;
   logic signed [skc_pkg::HIT_W-1:0]  res_count_in;
   logic [skc_pkg::KEY_W-1:0]         res_key_ff;
   logic [skc_pkg::KEY_W-1:0]         res_key_in;
   logic                              res_full_ff;
   logic                              res_full_in;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic                              rsp_found_ff;
   logic                              rsp_found_in;
   logic signed [skc_pkg::HIT_W-1:0]  rsp_count_ff;
   logic signed [skc_pkg::HIT_W-1:0]  rsp_count_in;
   logic [skc_pkg::KEY_W-1:0]         rsp_key_ff;
   logic [skc_pkg::KEY_W-1:0]         rsp_key_in;
   logic [skc_pkg::TOTAL_W-1:0]       rsp_total_ff;
   logic [skc_pkg::TOTAL_W-1:0]       rsp_total_in;
   logic                              rsp_full_ff;
   logic                              rsp_full_in;

   logic [skc_pkg::KEY_W-1:0] key_rd;
   logic [skc_pkg::CNT_W-1:0] cnt_rd;
   logic [IdxW-1:0]           ram_rd_addr;
   logic [IdxW-1:0]           ram_wr_addr;
   logic                      key_wr_en;
   logic                      cnt_wr_en;
   logic [skc_pkg::CNT_W-1:0] cnt_wr_data;

   logic                      key_eq;
   logic                      key_lt;
   logic [TotW-1:0]           b_lo;
   logic [TotW-1:0]           b_hi1;
   logic [TotW:0]             mid_sum;
   logic [IdxW-1:0]           mid_calc;
   logic                      more;
   logic [skc_pkg::CNT_W-1:0] cnt_sat;
   logic                      out_free;

   skc_pkg::rank_cmd_type rank_cmd;
   logic [IdxW-1:0]       rank_idx;
   logic                  sel_valid;
   logic [IdxW-1:0]       sel_idx;

   skc_ram #(
      .WIDTH (skc_pkg::KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (key_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (key_rd)
   );

   skc_ram #(
      .WIDTH (skc_pkg::CNT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (cnt_rd)
   );

   skc_rank #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_rank (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rank_cmd),
      .cmd_idx   (rank_idx),
      .sel_rank  (rank_ff),
      .sel_valid (sel_valid),
      .sel_idx   (sel_idx)
   );

   // one search step: compare probe, narrow bounds, form next midpoint
   always_comb begin
      key_eq = (key_rd == key_ff);
      key_lt = (key_rd < key_ff);
      if (state_ff == skc_pkg::ST_SEARCH_START) begin
         b_lo  = '0;
         b_hi1 = total_ff;
      end else if (key_lt) begin
         b_lo  = TotW'(mid_ff) + TotW'(1);
         b_hi1 = hi1_ff;
      end else begin
         b_lo  = lo_ff;
         b_hi1 = TotW'(mid_ff);
      end
      more     = (b_lo < b_hi1);
      mid_sum  = {1'b0, b_lo} + {1'b0, b_hi1} - (TotW + 1)'(1);
      mid_calc = mid_sum[IdxW:1];
      cnt_sat  = (cnt_rd == '1) ? cnt_rd : cnt_rd + skc_pkg::CNT_W'(1);
      out_free = !rsp_valid_ff || rsp_if.ready;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skc_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               case (req_if.command)
                  skc_pkg::CMD_LOAD:  state_in = skc_pkg::ST_LOAD;
                  skc_pkg::CMD_HIT:   state_in = skc_pkg::ST_SEARCH_START;
                  skc_pkg::CMD_QUERY: state_in = skc_pkg::ST_SEARCH_START;
                  default:            state_in = skc_pkg::ST_RANK_READ;
               endcase
            end
         end
         skc_pkg::ST_LOAD:         state_in = skc_pkg::ST_FINISH;
         skc_pkg::ST_SEARCH_START: begin
            state_in = more ? skc_pkg::ST_SEARCH : skc_pkg::ST_FINISH;
         end
         skc_pkg::ST_SEARCH: begin
            if (key_eq) begin
               state_in = (cmd_ff == skc_pkg::CMD_HIT) ? skc_pkg::ST_BUMP
                                                       : skc_pkg::ST_FINISH;
            end else begin
               state_in = more ? skc_pkg::ST_SEARCH : skc_pkg::ST_FINISH;
            end
         end
         skc_pkg::ST_BUMP:      state_in = skc_pkg::ST_SORT_A;
         skc_pkg::ST_SORT_A:    state_in = skc_pkg::ST_SORT_B;
         skc_pkg::ST_SORT_B:    state_in = skc_pkg::ST_SORT_C;
         skc_pkg::ST_SORT_C:    state_in = skc_pkg::ST_INSERT;
         skc_pkg::ST_INSERT:    state_in = skc_pkg::ST_FINISH;
         skc_pkg::ST_RANK_READ: begin
            state_in = sel_valid ? skc_pkg::ST_RANK_DATA : skc_pkg::ST_FINISH;
         end
         skc_pkg::ST_RANK_DATA: state_in = skc_pkg::ST_FINISH;
         skc_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = skc_pkg::ST_IDLE;
            end
         end
         default:               state_in = skc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      rank_in      = rank_ff;
      total_in     = total_ff;
      lo_in        = lo_ff;
      hi1_in       = hi1_ff;
      mid_in       = mid_ff;
      new_cnt_in   = new_cnt_ff;
      res_found_in = res_found_ff;
      res_count_in = res_count_ff;
      res_key_in   = res_key_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_total_in = rsp_total_ff;
      rsp_full_in  = rsp_full_ff;

      ram_rd_addr    = (state_ff == skc_pkg::ST_RANK_READ) ? sel_idx : mid_calc;
      ram_wr_addr    = (state_ff == skc_pkg::ST_LOAD) ? total_ff[IdxW-1:0] : mid_ff;
      key_wr_en      = 1'b0;
      cnt_wr_en      = 1'b0;
      cnt_wr_data    = (state_ff == skc_pkg::ST_LOAD) ? '0 : new_cnt_ff;
      rank_cmd.op    = skc_pkg::RK_NONE;
      rank_cmd.count = new_cnt_ff;
      rank_idx       = mid_ff;

      case (state_ff)
         skc_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               cmd_in       = skc_pkg::command_type'(req_if.command);
               key_in       = req_if.key;
               rank_in      = req_if.rank;
               res_found_in = 1'b0;
               res_count_in = skc_pkg::HIT_ABSENT;
               res_key_in   = '0;
               res_full_in  = 1'b0;
            end
         end
         skc_pkg::ST_LOAD: begin
            if (total_ff == TotW'(TABLE_DEPTH)) begin
               res_full_in = 1'b1;
            end else begin
               key_wr_en    = 1'b1;
               cnt_wr_en    = 1'b1;
               res_found_in = 1'b1;
               res_count_in = '0;
               total_in     = total_ff + TotW'(1);
               if (total_ff < TotW'(skc_pkg::TOP_SLOTS)) begin
                  rank_cmd.op = skc_pkg::RK_LOAD;
                  rank_idx    = total_ff[IdxW-1:0];
               end
            end
         end
         skc_pkg::ST_SEARCH_START: begin
            lo_in  = b_lo;
            hi1_in = b_hi1;
            mid_in = mid_calc;
         end
         skc_pkg::ST_SEARCH: begin
            if (key_eq) begin
               res_found_in = 1'b1;
               if (cmd_ff == skc_pkg::CMD_HIT) begin
                  new_cnt_in   = cnt_sat;
                  res_count_in = $signed({1'b0, cnt_sat});
               end else begin
                  res_count_in = $signed({1'b0, cnt_rd});
               end
            end else begin
               lo_in  = b_lo;
               hi1_in = b_hi1;
               mid_in = mid_calc;
            end
         end
         skc_pkg::ST_BUMP: begin
            cnt_wr_en   = 1'b1;
            rank_cmd.op = skc_pkg::RK_BUMP;
         end
         skc_pkg::ST_SORT_A: rank_cmd.op = skc_pkg::RK_SORT01;
         skc_pkg::ST_SORT_B: rank_cmd.op = skc_pkg::RK_SORT02;
         skc_pkg::ST_SORT_C: rank_cmd.op = skc_pkg::RK_SORT12;
         skc_pkg::ST_INSERT: rank_cmd.op = skc_pkg::RK_INSERT;
         skc_pkg::ST_RANK_DATA: begin
            res_found_in = 1'b1;
            res_count_in = $signed({1'b0, cnt_rd});
            res_key_in   = key_rd;
         end
         skc_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_count_in = res_count_ff;
               rsp_key_in   = res_key_ff;
               rsp_total_in = skc_pkg::TOTAL_W'(total_ff);
               rsp_full_in  = res_full_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skc_pkg::ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      rank_ff      <= rank_in;
      lo_ff        <= lo_in;
      hi1_ff       <= hi1_in;
      mid_ff       <= mid_in;
      new_cnt_ff   <= new_cnt_in;
      res_found_ff <= res_found_in;
      res_count_ff <= res_count_in;
      res_key_ff   <= res_key_in;
      res_full_ff  <= res_full_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_total_ff <= rsp_total_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign req_if.ready       = (state_ff == skc_pkg::ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.found       = rsp_found_ff;
   assign rsp_if.hit_count   = rsp_count_ff;
   assign rsp_if.ranked_key  = rsp_key_ff;
   assign rsp_if.entry_total = rsp_total_ff;
   assign rsp_if.table_full  = rsp_full_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TotW'(TABLE_DEPTH))
      else $error("entry total beyond table depth");

   a_load_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skc_pkg::ST_LOAD) && (total_ff != TotW'(TABLE_DEPTH))
      |=> total_ff == $past(total_ff) + TotW'(1))
      else $error("accepted load did not advance the entry total");

   a_probe_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skc_pkg::ST_SEARCH)
      |-> (lo_ff <= TotW'(mid_ff)) && (TotW'(mid_ff) < hi1_ff))
      else $error("search probe outside its bounds");

   a_finish_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skc_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_if.ready)
      |=> rsp_valid_ff && (state_ff == skc_pkg::ST_IDLE))
      else $error("finished item not handed to the output register");

endmodule

[tb/sorted_key_counter_top_three_unit_tb.sv]
`timescale 1ns / 100ps

module sorted_key_counter_top_three_unit_tb;

   localparam int KEY_TABLE_DEPTH = skc_pkg::TABLE_DEPTH_DEF;
   localparam int STEP_ROWS       = 24;

   typedef struct packed {
      logic                             found;
      logic signed [skc_pkg::HIT_W-1:0] hit_count;
      logic [skc_pkg::KEY_W-1:0]        ranked_key;
      logic [skc_pkg::TOTAL_W-1:0]      entry_total;
      logic                             table_full;
   } lookup_result_type;

   typedef struct packed {
      skc_pkg::command_type             op;
      logic [skc_pkg::KEY_W-1:0]        probe;
      logic [skc_pkg::RANK_W-1:0]       slot;
      logic                             typed;
      lookup_result_type                want;
   } step_row_type;

   localparam logic [skc_pkg::KEY_W-1:0] KEY_ONES = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   skc_req_if req_bus ();
   skc_rsp_if rsp_bus ();

   sorted_key_counter_top_three_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [skc_pkg::KEY_W-1:0] key_tab  [KEY_TABLE_DEPTH];
   logic [skc_pkg::CNT_W-1:0] hits_tab [KEY_TABLE_DEPTH];
   int                        n_loaded;
   int                        slot_idx [skc_pkg::TOP_SLOTS];
   bit                        slot_on  [skc_pkg::TOP_SLOTS];

   lookup_result_type         pending_results [$];
   int                        faults;
   bit                        steady;
   logic [skc_pkg::KEY_W-1:0] top_key;

   step_row_type script [STEP_ROWS] = '{
      '{skc_pkg::CMD_QUERY, 64'h0, 2'd0, 1'b1,
        '{1'b0, skc_pkg::HIT_ABSENT, 64'h0, 11'd0, 1'b0}},
      '{skc_pkg::CMD_RANK,  64'h0, 2'd0, 1'b1,
        '{1'b0, skc_pkg::HIT_ABSENT, 64'h0, 11'd0, 1'b0}},
      '{skc_pkg::CMD_HIT,   KEY_ONES, 2'd0, 1'b1,
        '{1'b0, skc_pkg::HIT_ABSENT, 64'h0, 11'd0, 1'b0}},
      '{skc_pkg::CMD_LOAD,  64'h0,  2'd0, 1'b1, '{1'b1, 33'sd0, 64'h0, 11'd1, 1'b0}},
      '{skc_pkg::CMD_LOAD,  64'h10, 2'd3, 1'b1, '{1'b1, 33'sd0, 64'h0, 11'd2, 1'b0}},
      '{skc_pkg::CMD_RANK,  64'h0,  2'd0, 1'b0, '0},
      '{skc_pkg::CMD_LOAD,  64'h20, 2'd2, 1'b1, '{1'b1, 33'sd0, 64'h0, 11'd3, 1'b0}},
      '{skc_pkg::CMD_LOAD,  64'h30, 2'd1, 1'b1, '{1'b1, 33'sd0, 64'h0, 11'd4, 1'b0}},
      '{skc_pkg::CMD_HIT,   64'h30, 2'd0, 1'b0, '0},
      '{skc_pkg::CMD_HIT,   64'h30, 2'd3, 1'b0, '0},
      '{skc_pkg::CMD_HIT,   64'h10, 2'd0, 1'b0, '0},
      '{skc_pkg::CMD_HIT,   64'h25, 2'd0, 1'b1,
        '{1'b0, skc_pkg::HIT_ABSENT, 64'h0, 11'd4, 1'b0}},
      '{skc_pkg::CMD_QUERY, 64'h30, 2'd0, 1'b0, '0},
      '{skc_pkg::CMD_RANK,  64'h0,  2'd0, 1'b0, '0},
      '{skc_pkg::CMD_RANK,  64'h0,  2'd1, 1'b0, '0},
      '{skc_pkg::CMD_RANK,  64'h0,  2'd2, 1'b0, '0},
      '{skc_pkg::CMD_RANK,  KEY_ONES, 2'd3, 1'b1,
        '{1'b0, skc_pkg::HIT_ABSENT, 64'h0, 11'd4, 1'b0}},
      '{skc_pkg::CMD_HIT,   64'h20, 2'd0, 1'b0, '0},
      '{skc_pkg::CMD_HIT,   64'h20, 2'd1, 1'b0, '0},
      '{skc_pkg::CMD_HIT,   64'h20, 2'd2, 1'b0, '0},
      '{skc_pkg::CMD_RANK,  64'h0,  2'd0, 1'b0, '0},
      '{skc_pkg::CMD_QUERY, KEY_ONES, 2'd0, 1'b1,
        '{1'b0, skc_pkg::HIT_ABSENT, 64'h0, 11'd4, 1'b0}},
      '{skc_pkg::CMD_HIT,   64'h0,  2'd0, 1'b0, '0},
      '{skc_pkg::CMD_RANK,  64'h0,  2'd2, 1'b0, '0}
   };

   function automatic longint slot_weight(int s);
      if (!slot_on[s]) return -1;
      return longint'(hits_tab[slot_idx[s]]);
   endfunction

   function automatic void order_slots(int a, int b);
      int ti;
      bit tv;
      if (slot_weight(a) < slot_weight(b)) begin
         ti = slot_idx[a];
         tv = slot_on[a];
         slot_idx[a] = slot_idx[b];
         slot_on[a]  = slot_on[b];
         slot_idx[b] = ti;
         slot_on[b]  = tv;
      end
   endfunction

   function automatic lookup_result_type apply_item(skc_pkg::command_type op,
                                                    logic [skc_pkg::KEY_W-1:0] probe,
                                                    logic [skc_pkg::RANK_W-1:0] slot);
      lookup_result_type res;
      int lo, hi, mid, pos;
      res = '{1'b0, skc_pkg::HIT_ABSENT, '0, '0, 1'b0};
      case (op)
         skc_pkg::CMD_LOAD: begin
            if (n_loaded >= KEY_TABLE_DEPTH) begin
               res.table_full = 1'b1;
            end else begin
               key_tab[n_loaded]  = probe;
               hits_tab[n_loaded] = '0;
               if (n_loaded < skc_pkg::TOP_SLOTS) begin
                  slot_idx[n_loaded] = n_loaded;
                  slot_on[n_loaded]  = 1'b1;
               end
               n_loaded++;
               res.found     = 1'b1;
               res.hit_count = '0;
            end
         end
         skc_pkg::CMD_HIT, skc_pkg::CMD_QUERY: begin
            pos = -1;
            lo  = 0;
            hi  = n_loaded - 1;
            while (lo <= hi && pos < 0) begin
               mid = (lo + hi) / 2;
               if (key_tab[mid] == probe) pos = mid;
               else if (key_tab[mid] < probe) lo = mid + 1;
               else hi = mid - 1;
            end
            if (pos >= 0) begin
               if (op == skc_pkg::CMD_HIT) begin
                  if (hits_tab[pos] != '1) hits_tab[pos]++;
                  order_slots(0, 1);
                  order_slots(0, 2);
                  order_slots(1, 2);
                  for (int i = 0; i < skc_pkg::TOP_SLOTS; i++) begin
                     if (slot_on[i] && slot_idx[i] == pos) break;
                     if (longint'(hits_tab[pos]) > slot_weight(i)) begin
                        for (int j = skc_pkg::TOP_SLOTS - 1; j > i; j--) begin
                           slot_idx[j] = slot_idx[j-1];
                           slot_on[j]  = slot_on[j-1];
                        end
                        slot_idx[i] = pos;
                        slot_on[i]  = 1'b1;
                        break;
                     end
                  end
               end
               res.found     = 1'b1;
               res.hit_count = {1'b0, hits_tab[pos]};
            end
         end
         default: begin
            if (slot < skc_pkg::TOP_SLOTS && slot_on[slot]) begin
               res.found      = 1'b1;
               res.hit_count  = {1'b0, hits_tab[slot_idx[slot]]};
               res.ranked_key = key_tab[slot_idx[slot]];
            end
         end
      endcase
      res.entry_total = n_loaded[skc_pkg::TOTAL_W-1:0];
      return res;
   endfunction

   task automatic push_item(skc_pkg::command_type op, logic [skc_pkg::KEY_W-1:0] probe,
                            logic [skc_pkg::RANK_W-1:0] slot, bit typed,
                            lookup_result_type want);
      int gap;
      lookup_result_type got;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= op;
      req_bus.key     <= probe;
      req_bus.rank    <= slot;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      got = apply_item(op, probe, slot);
      pending_results.insert(pending_results.size(), typed ? want : got);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_item(int load_pct);
      int r, pick;
      logic [skc_pkg::KEY_W-1:0] probe;
      r = $urandom_range(0, 99);
      if (r < load_pct && (n_loaded < 1000 || n_loaded >= KEY_TABLE_DEPTH)) begin
         top_key = top_key + 1 + ({$urandom, $urandom} >> 12);
         push_item(skc_pkg::CMD_LOAD, top_key, skc_pkg::RANK_W'($urandom_range(0, 3)),
                   1'b0, '0);
      end else if (r < load_pct + 45) begin
         pick = $urandom_range(0, 99);
         if (n_loaded == 0 || pick >= 90)
            probe = {$urandom, $urandom};
         else if (pick < 35)
            probe = key_tab[$urandom_range(0, (n_loaded < 8 ? n_loaded : 8) - 1)];
         else if (pick < 80)
            probe = key_tab[$urandom_range(0, n_loaded - 1)];
         else
            probe = key_tab[$urandom_range(0, n_loaded - 1)] + 1;
         push_item(($urandom_range(0, 3) == 0) ? skc_pkg::CMD_QUERY : skc_pkg::CMD_HIT,
                   probe, skc_pkg::RANK_W'($urandom_range(0, 3)), 1'b0, '0);
      end else begin
         push_item(skc_pkg::CMD_RANK, {$urandom, $urandom},
                   skc_pkg::RANK_W'($urandom_range(0, 3)), 1'b0, '0);
      end
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.command = skc_pkg::CMD_LOAD;
      req_bus.key     = '0;
      req_bus.rank    = '0;
      n_loaded        = 0;
      faults          = 0;
      steady          = 1'b0;
      for (int s = 0; s < skc_pkg::TOP_SLOTS; s++) begin
         slot_idx[s] = 0;
         slot_on[s]  = 1'b0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i])
         push_item(script[i].op, script[i].probe, script[i].slot, script[i].typed,
                   script[i].want);
      top_key = key_tab[n_loaded-1];
      drain();

      for (int i = 0; i < 250; i++) begin
         if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
         random_item(40);
      end

      drain();
      steady = 1'b0;
      push_item(skc_pkg::CMD_LOAD, top_key >> 1, 2'd0, 1'b0, '0);
      while (n_loaded < KEY_TABLE_DEPTH - 1) begin
         top_key = top_key + 1 + ({$urandom, $urandom} >> 12);
         push_item(skc_pkg::CMD_LOAD, top_key, skc_pkg::RANK_W'($urandom_range(0, 3)),
                   1'b0, '0);
      end
      push_item(skc_pkg::CMD_LOAD, KEY_ONES, 2'd0, 1'b0, '0);
      for (int i = 0; i < 40; i++)
         random_item(10);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (faults == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("result with no item outstanding");
            faults++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_bus.found);
               faults++;
            end
            if (rsp_bus.hit_count !== want.hit_count) begin
               $error("hit_count: expected %0d, got %0d", want.hit_count, rsp_bus.hit_count);
               faults++;
            end
            if (rsp_bus.ranked_key !== want.ranked_key) begin
               $error("ranked_key: expected %h, got %h", want.ranked_key, rsp_bus.ranked_key);
               faults++;
            end
            if (rsp_bus.entry_total !== want.entry_total) begin
               $error("entry_total: expected %0d, got %0d", want.entry_total,
                      rsp_bus.entry_total);
               faults++;
            end
            if (rsp_bus.table_full !== want.table_full) begin
               $error("table_full: expected %0d, got %0d", want.table_full,
                      rsp_bus.table_full);
               faults++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
